[hw/rtl/lfu_pkg.sv]
// Shared types and constants for the LFU cache.
package lfu_pkg;

    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int CAP_BITS   = 5;
    // Field widths in the sweep token and writeback command, sized for the
    // largest supported configuration (64 entries, 32-bit counts).
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 32;
    localparam int OCC_W      = 7;

    // Token that walks the cell chain gathering match, victim and free slot.
    typedef struct packed {
        logic                  found;
        logic [IDX_W-1:0]      f_idx;
        logic [VALUE_BITS-1:0] f_value;
        logic [IDX_W-1:0]      f_rank;
        logic [OCC_W-1:0]      occ;
        logic                  v_found;
        logic [IDX_W-1:0]      v_idx;
        logic [CNT_W-1:0]      v_count;
        logic [IDX_W-1:0]      v_rank;
        logic [KEY_BITS-1:0]   v_key;
        logic                  free_found;
        logic [IDX_W-1:0]      free_idx;
    } t_sweep;

    // Update broadcast to every cell at the end of a request.
    typedef struct packed {
        logic                  do_hit;
        logic [IDX_W-1:0]      hit_idx;
        logic [IDX_W-1:0]      hit_rank;
        logic                  put;
        logic [VALUE_BITS-1:0] value;
        logic [KEY_BITS-1:0]   key;
        logic                  do_evict;
        logic [IDX_W-1:0]      ev_idx;
        logic [IDX_W-1:0]      ev_rank;
        logic                  do_insert;
        logic [IDX_W-1:0]      ins_idx;
    } t_wb;

    localparam t_sweep SWEEP_INIT = '0;

endpackage

[hw/rtl/lfu_if.sv]
// Channel interfaces: request, response and configuration write.
interface lfu_req_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] key;
    logic signed [31:0] value;
    modport source (output valid, kind, key, value, input ready);
    modport sink   (input valid, kind, key, value, output ready);
endinterface

interface lfu_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic signed [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
    modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
    modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

interface lfu_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[hw/rtl/lfu_cache_replacement.sv]
// Top level: LFU cache with LRU tie-break built as a chain of entry cells.
// A request is taken only when the block is idle. A token then ripples down
// the row of ENTRIES cells, one cell per cycle, gathering the hit, the
// occupancy, the lowest-count/oldest victim and the first free slot; the
// write-back state then broadcasts the update to all cells and loads the
// response register, waiting while an earlier response is still untaken.
// The response waits in its register until taken; a new request may be
// accepted meanwhile. Capacity writes are always accepted.
module lfu_cache_replacement #(
    parameter int ENTRIES    = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lfu_req_if.sink   i_req,
    lfu_rsp_if.source o_rsp,
    lfu_cfg_if.sink   i_cfg
);
    import lfu_pkg::*;

    localparam int RANK_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CTR_BITS  = $clog2(ENTRIES + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_WB    = 2'd2;

    logic [1:0]            r_state;
    logic [CTR_BITS-1:0]   r_ctr;
    logic [CAP_BITS-1:0]   r_cap;
    logic                  r_kind;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;

    logic                  r_o_valid;
    logic                  r_o_hit;
    logic [VALUE_BITS-1:0] r_o_read;
    logic                  r_o_ev;
    logic [KEY_BITS-1:0]   r_o_ev_key;

    t_sweep tok [ENTRIES+1];
    t_wb    wb;
    logic   wb_fire;

    // Configuration register
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_BITS'(16);
        end else if (i_cfg.valid) begin
            r_cap <= i_cfg.data;
        end
    end

    // Cell chain
    assign tok[0] = SWEEP_INIT;
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        lfu_cell #(
            .IDX(g), .COUNT_BITS(COUNT_BITS), .RANK_BITS(RANK_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (r_key),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1]),
            .i_wb_en (wb_fire),
            .i_wb    (wb)
        );
    end

    // Decision from the token at the tail of the chain
    t_sweep           tail;
    logic [OCC_W-1:0] cap_ext;
    logic [OCC_W-1:0] cap_eff;
    logic             cap_zero;
    logic             is_hit;
    logic             is_evict;
    logic             is_insert;

    assign tail     = tok[ENTRIES];
    assign cap_ext  = OCC_W'(r_cap);
    assign cap_eff  = (cap_ext > OCC_W'(ENTRIES)) ? OCC_W'(ENTRIES) : cap_ext;
    assign cap_zero = (r_cap == '0);
    assign is_hit    = !cap_zero && tail.found;
    assign is_insert = !cap_zero && !tail.found && r_kind;
    assign is_evict  = is_insert && (tail.occ >= cap_eff);

    always_comb begin
        wb.do_hit    = is_hit;
        wb.hit_idx   = tail.f_idx;
        wb.hit_rank  = tail.f_rank;
        wb.put       = r_kind;
        wb.value     = r_value;
        wb.key       = r_key;
        wb.do_evict  = is_evict;
        wb.ev_idx    = tail.v_idx;
        wb.ev_rank   = tail.v_rank;
        wb.do_insert = is_insert;
        if (is_evict && (!tail.free_found || tail.v_idx < tail.free_idx)) begin
            wb.ins_idx = tail.v_idx;
        end else begin
            wb.ins_idx = tail.free_idx;
        end
    end

    assign wb_fire = (r_state == ST_WB) && (!r_o_valid || o_rsp.ready);

    // Request sequencing
    assign i_req.ready = (r_state == ST_IDLE);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ctr   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_req.valid) begin
                        r_state <= ST_SWEEP;
                        r_ctr   <= '0;
                    end
                end
                ST_SWEEP: begin
                    r_ctr <= r_ctr + 1'b1;
                    if (r_ctr == CTR_BITS'(ENTRIES - 1)) begin
                        r_state <= ST_WB;
                    end
                end
                ST_WB: begin
                    if (wb_fire) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_kind  <= i_req.kind;
            r_key   <= i_req.key;
            r_value <= i_req.value;
        end
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (wb_fire) begin
            r_o_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wb_fire) begin
            r_o_hit    <= is_hit;
            r_o_read   <= r_kind ? '0 : (is_hit ? tail.f_value : '1);
            r_o_ev     <= is_evict;
            r_o_ev_key <= is_evict ? tail.v_key : '0;
        end
    end

    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.hit         = r_o_hit;
    assign o_rsp.read_value  = r_o_read;
    assign o_rsp.evicted     = r_o_ev;
    assign o_rsp.evicted_key = r_o_ev_key;

endmodule

[hw/rtl/lfu_cell.sv]
// One cache entry cell: stores an entry, folds it into the passing token.
module lfu_cell #(
    parameter int IDX        = 0,
    parameter int COUNT_BITS = 16,
    parameter int RANK_BITS  = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [lfu_pkg::KEY_BITS-1:0]    i_key,
    input  lfu_pkg::t_sweep                 i_tok,
    output lfu_pkg::t_sweep                 o_tok,
    input  logic                            i_wb_en,
    input  lfu_pkg::t_wb                    i_wb
);
    import lfu_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic                  r_valid;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic [COUNT_BITS-1:0] r_count;
    logic [RANK_BITS-1:0]  r_rank;
    t_sweep                r_tok;
    t_sweep                n_tok;

    logic [IDX_W-1:0] rank_ext;
    logic [CNT_W-1:0] count_ext;
    logic             match;
    logic             take_victim;

    assign rank_ext  = IDX_W'(r_rank);
    assign count_ext = CNT_W'(r_count);
    assign match     = r_valid && (r_key == i_key);
    assign take_victim = r_valid && (!i_tok.v_found || count_ext < i_tok.v_count ||
                         (count_ext == i_tok.v_count && rank_ext > i_tok.v_rank));

    // Fold this entry into the token
    always_comb begin
        n_tok = i_tok;
        n_tok.occ = i_tok.occ + OCC_W'(r_valid);
        if (match && !i_tok.found) begin
            n_tok.found   = 1'b1;
            n_tok.f_idx   = MY_IDX;
            n_tok.f_value = r_value;
            n_tok.f_rank  = rank_ext;
        end
        if (take_victim) begin
            n_tok.v_found = 1'b1;
            n_tok.v_idx   = MY_IDX;
            n_tok.v_count = count_ext;
            n_tok.v_rank  = rank_ext;
            n_tok.v_key   = r_key;
        end
        if (!r_valid && !i_tok.free_found) begin
            n_tok.free_found = 1'b1;
            n_tok.free_idx   = MY_IDX;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
    end

    assign o_tok = r_tok;

    // Entry update from the broadcast command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wb_en) begin
            if (i_wb.do_hit) begin
                if (i_wb.hit_idx == MY_IDX) begin
                    if (i_wb.put) begin
                        r_value <= i_wb.value;
                    end
                    if (r_count != '1) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_rank <= '0;
                end else if (r_valid && rank_ext < i_wb.hit_rank) begin
                    r_rank <= r_rank + 1'b1;
                end
            end else if (i_wb.do_insert) begin
                if (i_wb.ins_idx == MY_IDX) begin
                    r_valid <= 1'b1;
                    r_key   <= i_wb.key;
                    r_value <= i_wb.value;
                    r_count <= COUNT_BITS'(1);
                    r_rank  <= '0;
                end else if (i_wb.do_evict && i_wb.ev_idx == MY_IDX) begin
                    r_valid <= 1'b0;
                end else if (r_valid) begin
                    if (i_wb.do_evict && rank_ext > i_wb.ev_rank) begin
                        r_rank <= r_rank;
                    end else begin
                        r_rank <= r_rank + 1'b1;
                    end
                end
            end
        end
    end

endmodule
